// ===== hdl/mcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg: shared constants and types for the midpoint circle rasteriser
// Widths, decision constants and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // field widths
  localparam int RADIUS_BITS = 6;
  localparam int CENTER_BITS = 11;
  localparam int COORD_BITS  = 12;

  // decision term grows to about 4 * radius in magnitude, plus sign
  localparam int DEC_BITS = RADIUS_BITS + 4;

  // cap on results per request
  localparam int MAX_RESULTS = 64;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS);

  // decision constants
  localparam logic signed [DEC_BITS-1:0] DEC_INIT      = DEC_BITS'(3);
  localparam logic signed [DEC_BITS-1:0] DEC_STRAIGHT  = DEC_BITS'(6);
  localparam logic signed [DEC_BITS-1:0] DEC_DIAGONAL  = DEC_BITS'(10);

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture a new request
    logic advance;  // step to the next point
  } mcr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic radius_zero;  // incoming request draws nothing
    logic last;         // current point is the final one
  } mcr_status_t;

endpackage

// ===== hdl/midpoint_circle_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer: midpoint circle point generator
// One request (centre, radius) yields one result per octant step, each
// carrying the eight symmetric points; last_step marks the final one.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | center_x, center_y, radius
//   out     | out_valid / out_ready| 8 coordinates, last_step
//
// A request is taken, then results come one per cycle while out_ready
// is high: about radius/sqrt(2) + 1 results, 45 for radius 63, from the
// one shared step unit in the datapath. A zero radius is accepted and
// gives no result. Synchronous reset returns the block to idle. A stall
// on out_ready holds the current result; in_ready is low until the last
// result of a request has been taken.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [mcr_pkg::CENTER_BITS-1:0] center_y,
  input  logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  x_plus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  x_minus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  x_plus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  x_minus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  y_plus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  y_minus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  y_plus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]  y_minus_col,
  output logic                                   last_step
);

  mcr_pkg::mcr_cmd_t    cmd;
  mcr_pkg::mcr_status_t status;

  // sequencer
  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // step unit and point formation
  mcr_dp u_dp (
    .clk         (clk),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .cmd         (cmd),
    .status      (status),
    .x_plus_col  (x_plus_col),
    .x_minus_col (x_minus_col),
    .x_plus_row  (x_plus_row),
    .x_minus_row (x_minus_row),
    .y_plus_row  (y_plus_row),
    .y_minus_row (y_minus_row),
    .y_plus_col  (y_plus_col),
    .y_minus_col (y_minus_col),
    .last_step   (last_step)
  );

endmodule

// ===== hdl/mcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_ctrl: sequencing for the midpoint circle rasteriser
// Accepts a request when idle and walks the datapath one point per result.
// ----------------------------------------------------------------------------
module mcr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mcr_pkg::mcr_status_t status,
  output mcr_pkg::mcr_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    EMIT
  } state_t;

  state_t state;

  // handshake outputs follow the state directly
  assign in_ready  = (state == IDLE);
  assign out_valid = (state == EMIT);

  assign cmd.load    = in_valid && in_ready;
  assign cmd.advance = out_valid && out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && !status.radius_zero) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_ready && status.last) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/mcr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_dp: datapath of the midpoint circle rasteriser
// Holds centre, offsets, decision and step count; forms the eight points.
// ----------------------------------------------------------------------------
module mcr_dp (
  input  logic                                       clk,
  input  logic signed [mcr_pkg::CENTER_BITS-1:0]     center_x,
  input  logic signed [mcr_pkg::CENTER_BITS-1:0]     center_y,
  input  logic        [mcr_pkg::RADIUS_BITS-1:0]     radius,
  input  mcr_pkg::mcr_cmd_t                          cmd,
  output mcr_pkg::mcr_status_t                       status,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      x_plus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      x_minus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      x_plus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      x_minus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      y_plus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      y_minus_row,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      y_plus_col,
  output logic signed [mcr_pkg::COORD_BITS-1:0]      y_minus_col,
  output logic                                       last_step
);

  // working registers
  logic signed [mcr_pkg::CENTER_BITS-1:0] held_cx;
  logic signed [mcr_pkg::CENTER_BITS-1:0] held_cy;
  logic        [mcr_pkg::RADIUS_BITS-1:0] col;
  logic        [mcr_pkg::RADIUS_BITS-1:0] row;
  logic signed [mcr_pkg::DEC_BITS-1:0]    dec;
  logic        [mcr_pkg::COUNT_BITS-1:0]  count;

  logic        [mcr_pkg::RADIUS_BITS-1:0] col_next;
  logic        [mcr_pkg::RADIUS_BITS-1:0] row_next;
  logic signed [mcr_pkg::DEC_BITS-1:0]    dec_next;
  logic signed [mcr_pkg::DEC_BITS-1:0]    col_d;
  logic signed [mcr_pkg::DEC_BITS-1:0]    row_d;
  logic signed [mcr_pkg::DEC_BITS-1:0]    rad_d;

  assign col_d = mcr_pkg::DEC_BITS'(col);
  assign row_d = mcr_pkg::DEC_BITS'(row);
  assign rad_d = mcr_pkg::DEC_BITS'(radius);

  // one midpoint step: straight when decision negative, else diagonal
  always_comb begin
    col_next = col + mcr_pkg::RADIUS_BITS'(1);
    if (dec < 0) begin
      row_next = row;
      dec_next = dec + (col_d <<< 2) + mcr_pkg::DEC_STRAIGHT;
    end else begin
      row_next = row - mcr_pkg::RADIUS_BITS'(1);
      dec_next = dec + ((col_d - row_d) <<< 2) + mcr_pkg::DEC_DIAGONAL;
    end
  end

  // final point when the octant closes or the result cap is hit
  assign last_step = (col_next >= row_next) ||
                     (count == mcr_pkg::COUNT_BITS'(mcr_pkg::MAX_RESULTS - 1));

  assign status.last        = last_step;
  assign status.radius_zero = (radius == '0);

  // register update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_cx <= center_x;
      held_cy <= center_y;
      col     <= '0;
      row     <= radius;
      dec     <= mcr_pkg::DEC_INIT - (rad_d <<< 1);
      count   <= '0;
    end else if (cmd.advance) begin
      col     <= col_next;
      row     <= row_next;
      dec     <= dec_next;
      count   <= count + mcr_pkg::COUNT_BITS'(1);
    end
  end

  // octant points, wrapping at coordinate width
  logic signed [mcr_pkg::COORD_BITS-1:0] cx_e;
  logic signed [mcr_pkg::COORD_BITS-1:0] cy_e;
  logic signed [mcr_pkg::COORD_BITS-1:0] col_e;
  logic signed [mcr_pkg::COORD_BITS-1:0] row_e;

  assign cx_e  = mcr_pkg::COORD_BITS'(held_cx);
  assign cy_e  = mcr_pkg::COORD_BITS'(held_cy);
  assign col_e = mcr_pkg::COORD_BITS'(col);
  assign row_e = mcr_pkg::COORD_BITS'(row);

  assign x_plus_col  = cx_e + col_e;
  assign x_minus_col = cx_e - col_e;
  assign x_plus_row  = cx_e + row_e;
  assign x_minus_row = cx_e - row_e;
  assign y_plus_row  = cy_e + row_e;
  assign y_minus_row = cy_e - row_e;
  assign y_plus_col  = cy_e + col_e;
  assign y_minus_col = cy_e - col_e;

endmodule

// ===== hdl/mcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_checker: port-level checks for the midpoint circle rasteriser
// Watches the handshakes and the symmetry of each result.
// ----------------------------------------------------------------------------
module mcr_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] x_plus_col,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] x_minus_col,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] x_plus_row,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] x_minus_row,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] y_plus_row,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] y_minus_row,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] y_plus_col,
  input  logic signed [mcr_pkg::COORD_BITS-1:0] y_minus_col,
  input  logic                                  last_step
);

  logic [mcr_pkg::COORD_BITS-1:0] sum_x_col;
  logic [mcr_pkg::COORD_BITS-1:0] sum_x_row;
  logic [mcr_pkg::COORD_BITS-1:0] sum_y_col;
  logic [mcr_pkg::COORD_BITS-1:0] sum_y_row;

  assign sum_x_col = x_plus_col + x_minus_col;
  assign sum_x_row = x_plus_row + x_minus_row;
  assign sum_y_col = y_plus_col + y_minus_col;
  assign sum_y_row = y_plus_row + y_minus_row;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_plus_col) &&
      $stable(y_plus_row) && $stable(last_step))
    else $error("result changed while stalled");

  // one request in flight: no new request while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && out_valid))
    else $error("request accepted while results pending");

  // the final result frees the input
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_step |=> in_ready && !out_valid)
    else $error("block not idle after final result");

  // an earlier result is always followed by another
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_step |=> out_valid)
    else $error("results stopped before final one");

  // each pair is symmetric about the same centre
  a_symmetry: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sum_x_col == sum_x_row) && (sum_y_col == sum_y_row))
    else $error("points not symmetric about centre");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .x_plus_col  (x_plus_col),
  .x_minus_col (x_minus_col),
  .x_plus_row  (x_plus_row),
  .x_minus_row (x_minus_row),
  .y_plus_row  (y_plus_row),
  .y_minus_row (y_minus_row),
  .y_plus_col  (y_plus_col),
  .y_minus_col (y_minus_col),
  .last_step   (last_step)
);
